/* design/sprs_pkg.sv */
// Package of shared constants and types for the shortest-path route statistics block.
package sprs_pkg;

    localparam int MAX_NODES   = 1024;
    localparam int MAX_EDGES   = 4096;
    localparam int WEIGHT_BITS = 30;

    localparam int NODE_W  = 11;
    localparam int NIDX_W  = $clog2(MAX_NODES);
    localparam int EIDX_W  = $clog2(MAX_EDGES);
    localparam int ECNT_W  = EIDX_W + 1;
    localparam int DIST_W  = 42;
    localparam int CNT_W   = 30;
    localparam int HOP_W   = 10;
    localparam int EDGE_W  = 2 * NODE_W + WEIGHT_BITS;

    localparam logic [CNT_W-1:0] ROUTE_MOD = CNT_W'(1000000007);

    // Per-node record: reached, settled, distance, routes, min hops, max hops.
    localparam int NREC_W = 2 + DIST_W + CNT_W + 2 * HOP_W;

    typedef struct packed {
        logic              reached;
        logic              settled;
        logic [DIST_W-1:0] cost;
        logic [CNT_W-1:0]  routes;
        logic [HOP_W-1:0]  min_hops;
        logic [HOP_W-1:0]  max_hops;
    } node_rec_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CLEAR,
        ST_SCAN_RD,
        ST_SCAN,
        ST_PICK,
        ST_SRC_RD,
        ST_EDGE_RD,
        ST_EDGE,
        ST_DST,
        ST_RELAX,
        ST_TGT,
        ST_OUT
    } state_t;

endpackage

/* design/sprs_ram.sv */
// Generic single-port-write, single-port-read RAM with registered read data.
module sprs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

/* design/shortest_path_route_stats.sv */
// Top level of the shortest-path route statistics block.
//
//  channel  direction  handshake       payload
//  in       input      valid / stall   mode, edge_source, edge_dest, edge_weight
//  out      output     valid / stall   distance, route_count, min_flights,
//                                      max_flights, reachable
//  cfg      input      valid / ready   node_count
//
// Load beats (mode 0) are taken while idle, so edges stream in at one per cycle.
// A start beat (mode 1) holds input stall high while the walk runs: a clearing
// pass over the node memory, then per settled node a scan over the node memory,
// a step to mark it settled, and a pass over the edge memory that reads each
// stored edge and relaxes the destination of an edge leaving that node, ending
// in a last scan and a fetch and registration of the target record. Both
// memories have one write and one read port each.
// Reset clears the edge count and the control state; memory contents are left as
// they are. A waiting result does not block further load beats.
module shortest_path_route_stats
    import sprs_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   valid,
    output logic                   stall,
    input  logic                   mode,
    input  logic [NODE_W-1:0]      edge_source,
    input  logic [NODE_W-1:0]      edge_dest,
    input  logic [WEIGHT_BITS-1:0] edge_weight,
    output logic                   out_valid,
    input  logic                   out_stall,
    output logic [DIST_W-1:0]      distance,
    output logic [CNT_W-1:0]       route_count,
    output logic [HOP_W-1:0]       min_flights,
    output logic [HOP_W-1:0]       max_flights,
    output logic                   reachable,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [NODE_W-1:0]      node_count
);

    state_t state_reg, state_next;

    logic [NODE_W-1:0]  ncfg_reg;
    logic [ECNT_W-1:0]  etot_reg;
    logic [NODE_W-1:0]  n_use;

    // Loop counters and working registers of the walk.
    logic [NODE_W-1:0]  idx_reg, idx_next;       // node scan index
    logic [NODE_W-1:0]  best_reg, best_next;     // best node of the scan, 0 = none
    logic [DIST_W-1:0]  bdist_reg, bdist_next;
    node_rec_t          urec_reg, urec_next;     // record of the node being settled
    logic [ECNT_W-1:0]  eidx_reg, eidx_next;
    logic [EDGE_W-1:0]  edge_reg, edge_next;
    logic [DIST_W-1:0]  nd_reg, nd_next;

    logic               ov_reg;
    logic [DIST_W-1:0]  o_dist_reg;
    logic [CNT_W-1:0]   o_cnt_reg;
    logic [HOP_W-1:0]   o_min_reg, o_max_reg;
    logic               o_reach_reg;
    logic               o_load;
    node_rec_t          o_rec;

    // Node memory.
    logic               n_we;
    logic [NIDX_W-1:0]  n_waddr, n_raddr;
    node_rec_t          n_wdata, n_rdata;
    logic [NREC_W-1:0]  n_rbits;

    // Edge memory.
    logic               e_we;
    logic [EIDX_W-1:0]  e_raddr;
    logic [EDGE_W-1:0]  e_rdata;
    logic [WEIGHT_BITS-1:0] w_fix;

    logic               in_acc, load_acc;
    logic [NODE_W-1:0]  e_src, e_dst;
    logic [WEIGHT_BITS-1:0] e_w;
    logic [CNT_W:0]     rsum;
    logic [HOP_W-1:0]   hop_inc_min, hop_inc_max;

    assign n_rdata = node_rec_t'(n_rbits);

    sprs_ram #(.WIDTH(NREC_W), .DEPTH(MAX_NODES)) u_node_ram (
        .clk   (clk),
        .we    (n_we),
        .waddr (n_waddr),
        .wdata (NREC_W'(n_wdata)),
        .raddr (n_raddr),
        .rdata (n_rbits)
    );

    sprs_ram #(.WIDTH(EDGE_W), .DEPTH(MAX_EDGES)) u_edge_ram (
        .clk   (clk),
        .we    (e_we),
        .waddr (etot_reg[EIDX_W-1:0]),
        .wdata ({edge_source, edge_dest, w_fix}),
        .raddr (e_raddr),
        .rdata (e_rdata)
    );

    // Input is taken only while idle; a waiting result does not stall loads,
    // but a start beat waits until the output register is free.
    assign stall     = (state_reg != ST_IDLE) || (mode && ov_reg);
    assign in_acc    = valid && !stall;
    assign load_acc  = in_acc && !mode;
    assign e_we      = load_acc && (etot_reg < ECNT_W'(MAX_EDGES));
    assign w_fix     = (edge_weight == '0) ? WEIGHT_BITS'(1) : edge_weight;
    assign cfg_ready = (state_reg == ST_IDLE);

    assign n_use = (ncfg_reg < NODE_W'(2)) ? NODE_W'(2) :
                   (ncfg_reg > NODE_W'(MAX_NODES)) ? NODE_W'(MAX_NODES) : ncfg_reg;

    assign e_src = edge_reg[EDGE_W-1 -: NODE_W];
    assign e_dst = edge_reg[WEIGHT_BITS +: NODE_W];
    assign e_w   = edge_reg[WEIGHT_BITS-1:0];

    assign rsum        = {1'b0, n_rdata.routes} + {1'b0, urec_reg.routes};
    assign hop_inc_min = urec_reg.min_hops + HOP_W'(1);
    assign hop_inc_max = urec_reg.max_hops + HOP_W'(1);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            ncfg_reg  <= NODE_W'(2);
            etot_reg  <= '0;
            ov_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_valid && cfg_ready)
            begin
                ncfg_reg <= node_count;
            end
            if (e_we)
            begin
                etot_reg <= etot_reg + ECNT_W'(1);
            end
            if (o_load)
            begin
                ov_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                ov_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg   <= idx_next;
        best_reg  <= best_next;
        bdist_reg <= bdist_next;
        urec_reg  <= urec_next;
        eidx_reg  <= eidx_next;
        edge_reg  <= edge_next;
        nd_reg    <= nd_next;
        if (o_load)
        begin
            o_reach_reg <= o_rec.reached;
            o_dist_reg  <= o_rec.reached ? o_rec.cost : '0;
            o_cnt_reg   <= o_rec.reached ? o_rec.routes : '0;
            o_min_reg   <= o_rec.reached ? o_rec.min_hops : '0;
            o_max_reg   <= o_rec.reached ? o_rec.max_hops : '0;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        idx_next   = idx_reg;
        best_next  = best_reg;
        bdist_next = bdist_reg;
        urec_next  = urec_reg;
        eidx_next  = eidx_reg;
        edge_next  = edge_reg;
        nd_next    = nd_reg;
        n_we       = 1'b0;
        n_waddr    = idx_reg[NIDX_W-1:0];
        n_wdata    = '0;
        n_raddr    = idx_reg[NIDX_W-1:0];
        e_raddr    = eidx_reg[EIDX_W-1:0];
        o_load     = 1'b0;
        o_rec      = n_rdata;

        unique case (state_reg)
            ST_IDLE:
            begin
                idx_next = NODE_W'(1);
                if (in_acc && mode)
                begin
                    state_next = ST_CLEAR;
                end
            end
            // Nodes are stored at address node-1. Node 1 starts reached, one route.
            ST_CLEAR:
            begin
                n_we    = 1'b1;
                n_waddr = NIDX_W'(idx_reg - NODE_W'(1));
                if (idx_reg == NODE_W'(1))
                begin
                    n_wdata.reached = 1'b1;
                    n_wdata.routes  = CNT_W'(1);
                end
                idx_next = idx_reg + NODE_W'(1);
                if (idx_reg == n_use)
                begin
                    state_next = ST_SCAN_RD;
                    idx_next   = NODE_W'(1);
                    best_next  = '0;
                end
            end
            ST_SCAN_RD:
            begin
                n_raddr    = '0;
                idx_next   = NODE_W'(1);
                state_next = ST_SCAN;
            end
            // Data for node idx arrives; read of idx+1 is issued alongside.
            ST_SCAN:
            begin
                n_raddr = NIDX_W'(idx_reg);
                if (n_rdata.reached && !n_rdata.settled &&
                    (best_reg == '0 || n_rdata.cost < bdist_reg))
                begin
                    best_next  = idx_reg;
                    bdist_next = n_rdata.cost;
                end
                idx_next = idx_reg + NODE_W'(1);
                if (idx_reg == n_use)
                begin
                    state_next = ST_PICK;
                end
            end
            ST_PICK:
            begin
                if (best_reg == '0)
                begin
                    n_raddr    = NIDX_W'(n_use - NODE_W'(1));
                    state_next = ST_TGT;
                end
                else
                begin
                    n_raddr    = NIDX_W'(best_reg - NODE_W'(1));
                    state_next = ST_SRC_RD;
                end
            end
            // Mark the chosen node settled and keep its record for relaxation.
            ST_SRC_RD:
            begin
                urec_next         = n_rdata;
                urec_next.settled = 1'b1;
                n_we              = 1'b1;
                n_waddr           = NIDX_W'(best_reg - NODE_W'(1));
                n_wdata           = urec_next;
                eidx_next         = '0;
                state_next        = ST_EDGE_RD;
            end
            ST_EDGE_RD:
            begin
                if (eidx_reg == etot_reg)
                begin
                    state_next = ST_SCAN_RD;
                    best_next  = '0;
                end
                else
                begin
                    state_next = ST_EDGE;
                end
            end
            ST_EDGE:
            begin
                edge_next = e_rdata;
                state_next = ST_DST;
            end
            ST_DST:
            begin
                eidx_next = eidx_reg + ECNT_W'(1);
                nd_next   = urec_reg.cost + DIST_W'(e_w);
                n_raddr   = NIDX_W'(e_dst - NODE_W'(1));
                if (e_src == best_reg && e_dst != '0 && e_dst <= n_use)
                begin
                    state_next = ST_RELAX;
                end
                else
                begin
                    state_next = ST_EDGE_RD;
                end
            end
            // Read-modify-write of the destination; the next edge is read only
            // after this write, so no overlap can occur.
            ST_RELAX:
            begin
                n_waddr = NIDX_W'(e_dst - NODE_W'(1));
                n_wdata = n_rdata;
                if (!n_rdata.reached || nd_reg < n_rdata.cost)
                begin
                    n_we             = 1'b1;
                    n_wdata.reached  = 1'b1;
                    n_wdata.cost     = nd_reg;
                    n_wdata.routes   = urec_reg.routes;
                    n_wdata.min_hops = hop_inc_min;
                    n_wdata.max_hops = hop_inc_max;
                end
                else if (nd_reg == n_rdata.cost)
                begin
                    n_we           = 1'b1;
                    n_wdata.routes = (rsum >= {1'b0, ROUTE_MOD}) ?
                                     CNT_W'(rsum - {1'b0, ROUTE_MOD}) : CNT_W'(rsum);
                    if (hop_inc_min < n_rdata.min_hops)
                    begin
                        n_wdata.min_hops = hop_inc_min;
                    end
                    if (hop_inc_max > n_rdata.max_hops)
                    begin
                        n_wdata.max_hops = hop_inc_max;
                    end
                end
                state_next = ST_EDGE_RD;
            end
            ST_TGT:
            begin
                n_raddr    = NIDX_W'(n_use - NODE_W'(1));
                state_next = ST_OUT;
            end
            ST_OUT:
            begin
                o_load     = 1'b1;
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // The target record is held in ST_OUT by reading it again in ST_TGT.
    assign out_valid   = ov_reg;
    assign distance    = o_dist_reg;
    assign route_count = o_cnt_reg;
    assign min_flights = o_min_reg;
    assign max_flights = o_max_reg;
    assign reachable   = o_reach_reg;

    a_no_start_while_full: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_OUT) |-> !ov_reg)
        else $error("result overwritten");
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        etot_reg <= ECNT_W'(MAX_EDGES))
        else $error("edge count overflow");
    a_cfg_idle: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_ready |-> (state_reg == ST_IDLE))
        else $error("config taken while busy");
    a_out_follows: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_OUT) |=> ov_reg)
        else $error("result lost");

endmodule
